@@ rtl/slpseq_pkg.sv @@
// ----------------------------------------------------------------------------
// Status LED pattern sequencer package
// Shared constants, code values and the command and status bundles that pass
// between the sequencer controller and its datapath.
// ----------------------------------------------------------------------------
package slpseq_pkg;

   // Block sizing.
   localparam int NUM_LEDS         = 3;
   localparam int TICKS_PER_SECOND = 10;
   localparam int LED_IDX_W        = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   // Field widths of the item and result.
   localparam int FUNC_W    = 2;
   localparam int IDX_W     = 2;
   localparam int MODE_W    = 4;
   localparam int TIMEOUT_W = 16;
   localparam int PHASE_W   = 4;
   localparam int LEVELS_W  = 3;

   // Pattern boundaries for the pulse modes.
   localparam logic [PHASE_W-1:0] DOUBLE_END = PHASE_W'(4);
   localparam logic [PHASE_W-1:0] TRIPLE_END = PHASE_W'(6);

   // Item kinds.
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLASH = 2'd2;

   // LED modes.
   localparam logic [MODE_W-1:0] MODE_HOLD   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_OFF    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_ON     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 4'd3;
   localparam logic [MODE_W-1:0] MODE_FLASH  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_SLOW   = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FAST   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_DOUBLE = 4'd7;
   localparam logic [MODE_W-1:0] MODE_TRIPLE = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load_item;
      logic                 apply_cmd;
      logic                 tick_step;
      logic [LED_IDX_W-1:0] tick_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [LEVELS_W-1:0] levels;
   } dp_stat_type;

endpackage

@@ rtl/status_led_pattern_sequencer.sv @@
// ----------------------------------------------------------------------------
// Status LED pattern sequencer
// Drives three status LEDs from tick, set-mode and flash items on a stream.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item yields one result carrying
// the LED levels after that item. A tick walks the LEDs one per clock through
// a single shared update unit and then waits in a done state until the output
// register is free; a set or flash command takes one command step before that
// done state. The result sits in an output register, so a new item is taken as
// soon as the previous one has moved there, even while the result still waits
// on rsp_tready. All state but the captured item is cleared directly by reset.
module status_led_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   // Item channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // led_index[1:0], mode[5:2], timeout_seconds[21:6], zeros
   input  logic [1:0]  req_tuser,   // func[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // led_levels[2:0], zeros
);

   slpseq_pkg::dp_cmd_type               cmd;
   slpseq_pkg::dp_stat_type              stat;
   logic [slpseq_pkg::LEVELS_W-1:0]      rsp_levels;

   // Sequencing and output register.
   slpseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_levels (rsp_levels),
      .cmd        (cmd),
      .stat       (stat)
   );

   // LED state and update logic.
   slpseq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_tuser),
      .req_led_index       (req_tdata[1:0]),
      .req_mode            (req_tdata[5:2]),
      .req_timeout_seconds (req_tdata[21:6]),
      .stat                (stat)
   );

   assign rsp_tdata = {5'b0, rsp_levels};

endmodule

@@ rtl/slpseq_datapath.sv @@
// ----------------------------------------------------------------------------
// Status LED pattern sequencer datapath
// Holds the captured item and the per-LED mode, phase, timeout and level, and
// updates one LED per step through a shared update unit.
// ----------------------------------------------------------------------------
module slpseq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  slpseq_pkg::dp_cmd_type               cmd,
   input  logic [slpseq_pkg::FUNC_W-1:0]        req_func,
   input  logic [slpseq_pkg::IDX_W-1:0]         req_led_index,
   input  logic [slpseq_pkg::MODE_W-1:0]        req_mode,
   input  logic [slpseq_pkg::TIMEOUT_W-1:0]     req_timeout_seconds,
   output slpseq_pkg::dp_stat_type              stat
);

   // Captured item.
   logic [slpseq_pkg::FUNC_W-1:0]    func_ff;
   logic [slpseq_pkg::IDX_W-1:0]     idx_ff;
   logic [slpseq_pkg::MODE_W-1:0]    new_mode_ff;
   logic [slpseq_pkg::TIMEOUT_W-1:0] tmo_ff;

   // Per-LED state.
   logic [slpseq_pkg::MODE_W-1:0]    mode_ff   [slpseq_pkg::NUM_LEDS];
   logic [slpseq_pkg::PHASE_W-1:0]   phase_ff  [slpseq_pkg::NUM_LEDS];
   logic [slpseq_pkg::TIMEOUT_W-1:0] remain_ff [slpseq_pkg::NUM_LEDS];
   logic                             armed_ff  [slpseq_pkg::NUM_LEDS];
   logic                             level_ff  [slpseq_pkg::NUM_LEDS];

   // Next values of the selected LED for a tick step.
   logic [slpseq_pkg::MODE_W-1:0]    mode_in;
   logic [slpseq_pkg::PHASE_W-1:0]   phase_in;
   logic [slpseq_pkg::TIMEOUT_W-1:0] remain_in;
   logic                             armed_in;
   logic                             level_in;

   logic [slpseq_pkg::PHASE_W-1:0]   cur_phase;
   logic [slpseq_pkg::LED_IDX_W-1:0] cmd_sel;
   logic                             cmd_ok;

   // Capture the item on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff     <= req_func;
         idx_ff      <= req_led_index;
         new_mode_ff <= req_mode;
         tmo_ff      <= req_timeout_seconds;
      end
   end

   // A set or flash command only acts on an existing LED.
   assign cmd_sel = slpseq_pkg::LED_IDX_W'(idx_ff);
   assign cmd_ok  = (32'(idx_ff) < slpseq_pkg::NUM_LEDS);

   // Shared tick update for the LED under the controller's index.
   always_comb begin
      cur_phase = phase_ff[cmd.tick_sel];
      mode_in   = mode_ff[cmd.tick_sel];
      remain_in = remain_ff[cmd.tick_sel];
      armed_in  = armed_ff[cmd.tick_sel];
      level_in  = level_ff[cmd.tick_sel];

      // Once a second the armed timeout counts down or expires.
      if ((cur_phase == '0) && armed_in) begin
         if (remain_in != '0) begin
            remain_in = remain_in - 1'b1;
         end else begin
            mode_in  = slpseq_pkg::MODE_OFF;
            armed_in = 1'b0;
         end
      end

      case (mode_in)
         slpseq_pkg::MODE_OFF: begin
            level_in = 1'b0;
         end
         slpseq_pkg::MODE_ON: begin
            level_in = 1'b1;
         end
         slpseq_pkg::MODE_TOGGLE: begin
            level_in = ~level_in;
            mode_in  = slpseq_pkg::MODE_HOLD;
         end
         slpseq_pkg::MODE_FLASH: begin
            if (cur_phase == '0) begin
               level_in = 1'b1;
            end else begin
               level_in = 1'b0;
               mode_in  = slpseq_pkg::MODE_HOLD;
            end
         end
         slpseq_pkg::MODE_SLOW: begin
            if (cur_phase == '0) level_in = ~level_in;
         end
         slpseq_pkg::MODE_FAST: begin
            if (cur_phase[0]) level_in = ~level_in;
         end
         slpseq_pkg::MODE_DOUBLE: begin
            if (cur_phase == '0) begin
               level_in = 1'b1;
            end else if (cur_phase < slpseq_pkg::DOUBLE_END) begin
               level_in = ~level_in;
            end
         end
         slpseq_pkg::MODE_TRIPLE: begin
            if (cur_phase == '0) begin
               level_in = 1'b1;
            end else if (cur_phase < slpseq_pkg::TRIPLE_END) begin
               level_in = ~level_in;
            end
         end
         default: begin
            // Hold and unused codes keep the level.
         end
      endcase

      // Phase advances and wraps once per second.
      if (cur_phase == slpseq_pkg::PHASE_W'(slpseq_pkg::TICKS_PER_SECOND - 1)) begin
         phase_in = '0;
      end else begin
         phase_in = cur_phase + 1'b1;
      end
   end

   // Per-LED state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < slpseq_pkg::NUM_LEDS; i++) begin
            mode_ff[i]   <= slpseq_pkg::MODE_OFF;
            phase_ff[i]  <= '0;
            remain_ff[i] <= '0;
            armed_ff[i]  <= 1'b0;
            level_ff[i]  <= 1'b0;
         end
      end else if (cmd.tick_step) begin
         mode_ff[cmd.tick_sel]   <= mode_in;
         phase_ff[cmd.tick_sel]  <= phase_in;
         remain_ff[cmd.tick_sel] <= remain_in;
         armed_ff[cmd.tick_sel]  <= armed_in;
         level_ff[cmd.tick_sel]  <= level_in;
      end else if (cmd.apply_cmd && cmd_ok) begin
         case (func_ff)
            slpseq_pkg::FUNC_SET: begin
               mode_ff[cmd_sel]   <= new_mode_ff;
               phase_ff[cmd_sel]  <= '0;
               remain_ff[cmd_sel] <= tmo_ff;
               armed_ff[cmd_sel]  <= (tmo_ff != '0);
            end
            slpseq_pkg::FUNC_FLASH: begin
               mode_ff[cmd_sel]  <= slpseq_pkg::MODE_FLASH;
               phase_ff[cmd_sel] <= '0;
            end
            default: begin
               // Ticks and the unused code change nothing here.
            end
         endcase
      end
   end

   // Levels of the LEDs that fit in the result.
   for (genvar g = 0; g < slpseq_pkg::LEVELS_W; g++) begin : g_levels
      if (g < slpseq_pkg::NUM_LEDS) begin : g_led
         assign stat.levels[g] = level_ff[g];
      end else begin : g_none
         assign stat.levels[g] = 1'b0;
      end
   end

endmodule

@@ rtl/slpseq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Status LED pattern sequencer controller
// Takes items, steps the datapath through a command or a tick over every LED,
// and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module slpseq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slpseq_pkg::FUNC_W-1:0]     req_func,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slpseq_pkg::LEVELS_W-1:0]   rsp_levels,
   output slpseq_pkg::dp_cmd_type            cmd,
   input  slpseq_pkg::dp_stat_type           stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_TICK,
      ST_DONE
   } state_type;

   state_type                           state_ff;
   logic [slpseq_pkg::LED_IDX_W-1:0]    cnt_ff;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [slpseq_pkg::LEVELS_W-1:0]     rsp_levels_ff;
   logic                                req_xfer;
   logic                                out_free;
   logic                                last_led;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_led   = (cnt_ff == slpseq_pkg::LED_IDX_W'(slpseq_pkg::NUM_LEDS - 1));

   // The result stays valid until its transfer, and a finished item refills it.
   assign rsp_valid_in = ((state_ff == ST_DONE) && out_free) ||
                         (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_levels = rsp_levels_ff;

   // Datapath commands.
   assign cmd.load_item = req_xfer;
   assign cmd.apply_cmd = (state_ff == ST_CMD);
   assign cmd.tick_step = (state_ff == ST_TICK);
   assign cmd.tick_sel  = cnt_ff;

   // Sequencer state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_levels_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  cnt_ff   <= '0;
                  state_ff <= (req_func == slpseq_pkg::FUNC_TICK) ? ST_TICK : ST_CMD;
               end
            end
            ST_CMD: begin
               state_ff <= ST_DONE;
            end
            ST_TICK: begin
               if (last_led) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_levels_ff <= stat.levels;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The tick index never leaves the range of LEDs.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (32'(cnt_ff) < slpseq_pkg::NUM_LEDS))
      else $error("tick index beyond the last LED");

   // An accepted tick starts its sweep at the first LED.
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_func == slpseq_pkg::FUNC_TICK))
      |=> ((state_ff == ST_TICK) && (cnt_ff == '0)))
      else $error("tick did not start at the first LED");

   // A finished item with a free output produces exactly one result.
   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item did not reach the output");

   // A pending result is not overwritten before its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_levels_ff)))
      else $error("pending result lost or changed");

endmodule
